// ===== design/cfq_pkg.sv =====
// Shared types and codes for the circular FIFO queue.
`default_nettype none

package cfq_pkg;

	localparam int DATA_W = 32;
	localparam int FILL_W = 8;

	// Request codes.
	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_READ = -32'sd1;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] push_value;
	} cfq_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]               status;
		logic                     is_empty;
		logic [FILL_W-1:0]        fill_count;
	} cfq_rsp_t;

	// Per-cell controls: shift toward the front, or load the pushed word.
	typedef struct packed {
		logic shift;
		logic load;
	} cfq_cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/cfq_cell.sv =====
// One storage cell of the shifting queue chain.
`default_nettype none

module cfq_cell
	import cfq_pkg::*;
(
	input  wire logic                     clk,
	input  wire cfq_cell_ctl_t            ctl,
	input  wire logic signed [DATA_W-1:0] push_value,
	input  wire logic signed [DATA_W-1:0] next_data,
	output logic signed [DATA_W-1:0]      data
);

	logic signed [DATA_W-1:0] data_q;

	// Shift on pop, load on push to this position; hold otherwise.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= next_data;
		end else if (ctl.load) begin
			data_q <= push_value;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== design/cfq_out_skid.sv =====
// Output register with a skid stage for the response channel.
`default_nettype none

module cfq_out_skid
	import cfq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire cfq_rsp_t load_rsp,
	output logic          full,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output cfq_rsp_t      rsp
);

	logic     out_v_q;
	logic     skid_v_q;
	cfq_rsp_t out_q;
	cfq_rsp_t skid_q;
	logic     drain;

	assign drain = out_v_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (drain) begin
				skid_v_q <= 1'b0;
			end
		end else if (load) begin
			if (out_v_q && !drain) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (drain) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (load) begin
			if (out_v_q && !drain) begin
				skid_q <= load_rsp;
			end else begin
				out_q <= load_rsp;
			end
		end
	end

	assign full      = skid_v_q;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

// ===== design/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue: cell chain, fill counter and response buffer.
// A response is registered in the output register, or in the skid stage while it stalls.
// Throughput: one request per cycle while the skid stage is free (req_stall low).
// A skid stage lets one more request in while a response is held by rsp_stall.
// Reset clears the fill count and the response valids; cell contents stay undefined.
`default_nettype none

module circular_fifo_queue
	import cfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 128
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire cfq_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output cfq_rsp_t      rsp
);

	// Count must hold QUEUE_DEPTH itself.
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;

	logic accept;
	logic is_push;
	logic is_pop;
	logic is_peek;
	logic empty_now;
	logic full_now;
	logic push_ok;
	logic pop_ok;
	logic buf_full;

	cfq_rsp_t res;

	logic signed [DATA_W-1:0] cell_data [QUEUE_DEPTH];

	// A request enters whenever the skid stage is free.
	assign req_stall = buf_full;
	assign accept    = req_valid && !req_stall;

	assign is_push   = req.req_type == REQ_PUSH;
	assign is_pop    = req.req_type == REQ_POP;
	assign is_peek   = req.req_type == REQ_PEEK;
	assign empty_now = count_q == '0;
	assign full_now  = count_q == CW'(QUEUE_DEPTH);

	// Drop pushes to a full queue; ignore pops on an empty one.
	assign push_ok = accept && is_push && !full_now;
	assign pop_ok  = accept && is_pop && !empty_now;

	always_comb begin
		count_nxt = count_q;
		if (push_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (pop_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Cell zero always holds the front entry: a pop shifts every cell one step
	// toward the front, a push lands in the first free cell.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cfq_cell_ctl_t            ctl;
		logic signed [DATA_W-1:0] next_data;

		assign ctl.shift = pop_ok;
		assign ctl.load  = push_ok && (count_q == CW'(i));

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		cfq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.push_value (req.push_value),
			.next_data  (next_data),
			.data       (cell_data[i])
		);
	end

	// Build the response from the front cell and the updated count.
	always_comb begin
		res.read_value = '0;
		res.status     = ST_OK;
		if (is_push) begin
			if (full_now) begin
				res.status = ST_FULL;
			end
		end else if (is_pop || is_peek) begin
			if (empty_now) begin
				res.read_value = EMPTY_READ;
				res.status     = ST_EMPTY;
			end else begin
				res.read_value = cell_data[0];
			end
		end
		res.is_empty   = count_nxt == '0;
		res.fill_count = FILL_W'(count_nxt);
	end

	cfq_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.load_rsp  (res),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count exceeds queue depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not decrement fill count");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no response pending");
`endif

endmodule

`default_nettype wire
